// ----- hw/rtl/avrsde_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package avrsde_pkg;

  localparam int PC_W = 22;
  localparam int WORD_W = 16;
  localparam int SREG_W = 8;
  localparam int CYC_W = 3;
  localparam int CFG_DATA_W = 22;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [4:0] op_t;

  localparam cfg_idx_t CFG_WIDE_RETURN = 2'd0;
  localparam cfg_idx_t CFG_STACK_MASK = 2'd1;
  localparam cfg_idx_t CFG_PROG_MASK = 2'd2;

  localparam op_t OP_NOP   = 5'd0;
  localparam op_t OP_AND   = 5'd1;
  localparam op_t OP_MOV   = 5'd2;
  localparam op_t OP_LDI   = 5'd3;
  localparam op_t OP_LD    = 5'd4;
  localparam op_t OP_STS   = 5'd5;
  localparam op_t OP_PUSH  = 5'd6;
  localparam op_t OP_POP   = 5'd7;
  localparam op_t OP_SWAP  = 5'd8;
  localparam op_t OP_ADIW  = 5'd9;
  localparam op_t OP_BSET  = 5'd10;
  localparam op_t OP_BCLR  = 5'd11;
  localparam op_t OP_BRZ   = 5'd12;
  localparam op_t OP_RJMP  = 5'd13;
  localparam op_t OP_RCALL = 5'd14;
  localparam op_t OP_RET   = 5'd15;
  localparam op_t OP_ILL   = 5'd16;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;

  function automatic op_t decode(input logic [WORD_W-1:0] w);
    op_t op;
    op = OP_ILL;
    if (w == 16'h0000) op = OP_NOP;
    else if ((w & 16'hFC00) == 16'h2000) op = OP_AND;
    else if ((w & 16'hFC00) == 16'h2C00) op = OP_MOV;
    else if (w[15:12] == 4'hE) op = OP_LDI;
    else if ((w & 16'hFE0F) == 16'h8008) op = OP_LD;
    else if ((w & 16'hFE0F) == 16'h900F) op = OP_POP;
    else if ((w & 16'hFE0F) == 16'h9200) op = OP_STS;
    else if ((w & 16'hFE0F) == 16'h920F) op = OP_PUSH;
    else if ((w & 16'hFE0F) == 16'h9402) op = OP_SWAP;
    else if ((w & 16'hFF8F) == 16'h9408) op = OP_BSET;
    else if ((w & 16'hFF8F) == 16'h9488) op = OP_BCLR;
    else if (w == 16'h9508) op = OP_RET;
    else if ((w & 16'hFF00) == 16'h9600) op = OP_ADIW;
    else if (w[15:12] == 4'hC) op = OP_RJMP;
    else if (w[15:12] == 4'hD) op = OP_RCALL;
    else if (((w & 16'hFC07) == 16'hF001) || ((w & 16'hFC07) == 16'hF401)) op = OP_BRZ;
    return op;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/avrsde_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface avrsde_in_if;
  import avrsde_pkg::*;
  logic valid;
  logic ready;
  logic [WORD_W-1:0] instr_word;
  logic [WORD_W-1:0] extra_word;
  modport source (output valid, instr_word, extra_word, input ready);
  modport sink (input valid, instr_word, extra_word, output ready);
endinterface

interface avrsde_out_if;
  import avrsde_pkg::*;
  logic valid;
  logic ready;
  logic [PC_W-1:0] next_pc;
  logic [SREG_W-1:0] status_flags;
  logic taken;
  logic illegal;
  logic [CYC_W-1:0] cycle_count;
  modport source (output valid, next_pc, status_flags, taken, illegal, cycle_count,
                  input ready);
  modport sink (input valid, next_pc, status_flags, taken, illegal, cycle_count,
                output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/avr_subset_decode_execute_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// AVR subset execute core.
// in_ch: one word per instruction (instr_word, extra_word = STS address).
// out_ch: one result word per instruction (next PC, SREG, taken, illegal,
// cycle count). Config: cfg_we/cfg_index/cfg_data, index 0 wide_return,
// 1 stack_mask, 2 prog_addr_mask; write only while idle.
// Steps: single-step ops, STS and PUSH finish in the execute step; LD
// and ADIW add one more step; POP reads then writes its byte; RCALL and
// RET move the 2 or 3 return bytes one at a time through the stack.
// The one-write data memory port and the one-write register file port
// set the pace: each stack byte takes its own step.
// A new word is taken in the same cycle its predecessor's result moves
// into the output register, not before.
// Reset: registers, SREG, PC clear, SP goes to all ones; the data memory
// is cleared by a sweep over all DATA_BYTES entries while in_ch.ready is
// low. Register file reads as zero via per-entry valid bits.
// Output stall: the result sits in the output register; the core finishes
// the next word and then waits in its done step until the slot frees.
module avr_subset_decode_execute_core #(
  parameter int DATA_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  avrsde_in_if.sink               in_ch,
  avrsde_out_if.source            out_ch,
  input  wire logic               cfg_we,
  input  wire avrsde_pkg::cfg_idx_t  cfg_index,
  input  wire avrsde_pkg::cfg_data_t cfg_data
);
  import avrsde_pkg::*;

  localparam int AW = $clog2(DATA_BYTES);
  localparam int MOD_SH = $clog2(65536 / DATA_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_ADIWH = 3'd3;
  localparam logic [2:0] S_LDW   = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Data address reduction modulo DATA_BYTES by shifted compare-subtract.
  function automatic logic [AW-1:0] dm_index(input logic [15:0] a);
    logic [16:0] v;
    v = {1'b0, a};
    for (int s = MOD_SH - 1; s >= 0; s--) begin
      if (v >= (17'(DATA_BYTES) << s)) v = v - (17'(DATA_BYTES) << s);
    end
    return v[AW-1:0];
  endfunction

  // config
  logic wide;
  logic [15:0] smask;
  logic [PC_W-1:0] pmask;

  // architectural state
  logic [2:0] state;
  logic [SREG_W-1:0] sreg;
  logic [15:0] sp;
  logic [PC_W-1:0] pc;
  logic [AW-1:0] clr_cnt;

  // current word
  logic [WORD_W-1:0] w_r;
  logic [WORD_W-1:0] ext_r;
  op_t op_r;
  logic [1:0] cnt;
  logic [7:0] adiw_hi;
  logic [23:0] pop_acc;

  // staged result
  logic [PC_W-1:0] res_pc;
  logic res_taken;
  logic res_ill;
  logic [CYC_W-1:0] res_cyc;

  // output register
  logic o_valid;
  logic [PC_W-1:0] o_pc;
  logic [SREG_W-1:0] o_sreg;
  logic o_taken;
  logic o_ill;
  logic [CYC_W-1:0] o_cyc;

  // register file memory
  logic [7:0] rf_mem [32];
  logic [31:0] rf_vld;
  logic [7:0] rf_qa, rf_qb;
  logic rv_a, rv_b;
  logic rf_we;
  logic [4:0] rf_wa, rf_ra, rf_rb;
  logic [7:0] rf_wd;

  // data memory
  logic [7:0] dm_mem [DATA_BYTES];
  logic [7:0] dm_q;
  logic dm_we, dm_re;
  logic [AW-1:0] dm_wa, dm_ra;
  logic [7:0] dm_wd;

  logic slot_free, acc;
  logic [7:0] opa, opb;
  logic [4:0] rd;
  logic [PC_W-1:0] cur, nxt, nxt2, rj_tgt, br_tgt;
  logic [1:0] rlen;
  logic [23:0] ret_val, pop_val;
  logic [15:0] adiw_sum;
  logic [5:0] adiw_k;
  logic [7:0] and_r;
  logic zflag, br_take;

  logic fin;
  logic [PC_W-1:0] fin_pc;
  logic fin_taken, fin_ill;
  logic [CYC_W-1:0] fin_cyc;
  logic [SREG_W-1:0] sreg_next;
  logic [15:0] sp_next;

  assign slot_free = !o_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) || ((state == S_DONE) && slot_free);
  assign acc = in_ch.valid && in_ch.ready;

  assign opa = rv_a ? rf_qa : 8'd0;
  assign opb = rv_b ? rf_qb : 8'd0;
  assign rd = w_r[8:4];
  assign cur = pc & pmask;
  assign nxt = (cur + 22'd1) & pmask;
  assign nxt2 = (cur + 22'd2) & pmask;
  assign rj_tgt = (cur + 22'd1 + {{10{w_r[11]}}, w_r[11:0]}) & pmask;
  assign br_tgt = (cur + 22'd1 + {{15{w_r[9]}}, w_r[9:3]}) & pmask;
  assign rlen = wide ? 2'd3 : 2'd2;
  assign ret_val = {2'b00, cur} + 24'd1;
  assign adiw_k = {w_r[7:6], w_r[3:0]};
  assign adiw_sum = {opb, opa} + {10'd0, adiw_k};
  assign and_r = opa & opb;
  assign zflag = sreg[FLAG_Z];
  // BRNE has bit 10 set
  assign br_take = w_r[10] ? !zflag : zflag;

  // popped bytes land one step after their read; top byte stays zero
  // for a two-byte return
  always_comb begin
    pop_val = pop_acc;
    unique case (cnt)
      2'd1: pop_val[7:0] = dm_q;
      2'd2: pop_val[15:8] = dm_q;
      2'd3: pop_val[23:16] = dm_q;
      default: ;
    endcase
  end

  // read addresses picked from the incoming word
  always_comb begin
    op_t in_op;
    in_op = decode(in_ch.instr_word);
    rf_ra = in_ch.instr_word[8:4];
    rf_rb = {in_ch.instr_word[9], in_ch.instr_word[3:0]};
    if (in_op == OP_LD) begin
      rf_ra = 5'd28;
      rf_rb = 5'd29;
    end else if (in_op == OP_ADIW) begin
      rf_ra = {2'b11, in_ch.instr_word[5:4], 1'b0};
      rf_rb = {2'b11, in_ch.instr_word[5:4], 1'b1};
    end
  end

  // memory ports and completion
  always_comb begin
    rf_we = 1'b0;
    rf_wa = rd;
    rf_wd = 8'd0;
    dm_we = 1'b0;
    dm_wa = clr_cnt;
    dm_wd = 8'd0;
    dm_re = 1'b0;
    dm_ra = dm_index(sp + {14'd0, cnt});
    fin = 1'b0;
    fin_pc = nxt;
    fin_taken = 1'b0;
    fin_ill = 1'b0;
    fin_cyc = 3'd1;
    sreg_next = sreg;
    sp_next = sp;
    unique case (state)
      S_CLEAR: dm_we = 1'b1;
      S_EXEC: begin
        unique case (op_r)
          OP_NOP: fin = 1'b1;
          OP_AND: begin
            rf_we = 1'b1;
            rf_wd = and_r;
            sreg_next = {sreg[7:5], and_r[7], 1'b0, and_r[7], and_r == 8'd0, sreg[FLAG_C]};
            fin = 1'b1;
          end
          OP_MOV: begin
            rf_we = 1'b1;
            rf_wd = opb;
            fin = 1'b1;
          end
          OP_LDI: begin
            rf_we = 1'b1;
            rf_wa = {1'b1, w_r[7:4]};
            rf_wd = {w_r[11:8], w_r[3:0]};
            fin = 1'b1;
          end
          OP_SWAP: begin
            rf_we = 1'b1;
            rf_wd = {opa[3:0], opa[7:4]};
            fin = 1'b1;
          end
          OP_BSET: begin
            sreg_next[w_r[6:4]] = 1'b1;
            fin = 1'b1;
          end
          OP_BCLR: begin
            sreg_next[w_r[6:4]] = 1'b0;
            fin = 1'b1;
          end
          OP_ADIW: begin
            rf_we = 1'b1;
            rf_wa = {2'b11, w_r[5:4], 1'b0};
            rf_wd = adiw_sum[7:0];
            sreg_next = {sreg[7:5],
                         adiw_sum[15] ^ (adiw_sum[15] & !opb[7]),
                         adiw_sum[15] & !opb[7],
                         adiw_sum[15],
                         adiw_sum == 16'd0,
                         !adiw_sum[15] & opb[7]};
          end
          OP_LD: begin
            dm_re = 1'b1;
            dm_ra = dm_index({opb, opa});
          end
          OP_STS: begin
            dm_we = 1'b1;
            dm_wa = dm_index(ext_r);
            dm_wd = opa;
            fin = 1'b1;
            fin_pc = nxt2;
            fin_cyc = 3'd2;
          end
          OP_PUSH: begin
            dm_we = 1'b1;
            dm_wa = dm_index(sp);
            dm_wd = opa;
            sp_next = (sp - 16'd1) & smask;
            fin = 1'b1;
            fin_cyc = 3'd2;
          end
          OP_POP: sp_next = (sp + 16'd1) & smask;
          OP_RET: sp_next = (sp + {14'd0, rlen}) & smask;
          OP_RJMP: begin
            fin = 1'b1;
            fin_pc = rj_tgt;
            fin_taken = 1'b1;
            fin_cyc = 3'd2;
          end
          OP_RCALL: ;
          OP_BRZ: begin
            fin = 1'b1;
            if (br_take) begin
              fin_pc = br_tgt;
              fin_taken = 1'b1;
              fin_cyc = 3'd2;
            end
          end
          default: begin
            fin = 1'b1;
            fin_ill = 1'b1;
            fin_pc = pc;
          end
        endcase
      end
      S_ADIWH: begin
        rf_we = 1'b1;
        rf_wa = {2'b11, w_r[5:4], 1'b1};
        rf_wd = adiw_hi;
        fin = 1'b1;
        fin_cyc = 3'd2;
      end
      S_LDW: begin
        rf_we = 1'b1;
        rf_wd = dm_q;
        fin = 1'b1;
        fin_cyc = 3'd2;
      end
      S_PUSH: begin
        dm_we = 1'b1;
        dm_wa = dm_index(sp + {14'd0, cnt});
        unique case (cnt)
          2'd0: dm_wd = ret_val[7:0];
          2'd1: dm_wd = ret_val[15:8];
          default: dm_wd = ret_val[23:16];
        endcase
        if (cnt == rlen - 2'd1) begin
          sp_next = (sp - {14'd0, rlen}) & smask;
          fin = 1'b1;
          fin_pc = rj_tgt;
          fin_taken = 1'b1;
          fin_cyc = 3'd3 + {2'b00, wide};
        end
      end
      S_POP: begin
        if (op_r == OP_POP) begin
          if (cnt == 2'd0) begin
            dm_re = 1'b1;
          end else begin
            rf_we = 1'b1;
            rf_wd = dm_q;
            fin = 1'b1;
            fin_cyc = 3'd2;
          end
        end else begin
          dm_re = (cnt != rlen);
          if (cnt == rlen) begin
            fin = 1'b1;
            fin_pc = pop_val[PC_W-1:0] & pmask;
            fin_taken = 1'b1;
            fin_cyc = 3'd4 + {2'b00, wide};
          end
        end
      end
      default: ;
    endcase
  end

  // register file: two registered reads, one write
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    rf_qa <= rf_mem[rf_ra];
    rf_qb <= rf_mem[rf_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      rv_a <= 1'b0;
      rv_b <= 1'b0;
    end else begin
      if (rf_we) rf_vld[rf_wa] <= 1'b1;
      rv_a <= rf_vld[rf_ra];
      rv_b <= rf_vld[rf_rb];
    end
  end

  // data memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (dm_we) dm_mem[dm_wa] <= dm_wd;
    if (dm_re) dm_q <= dm_mem[dm_ra];
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      wide <= 1'b0;
      smask <= 16'd4095;
      pmask <= 22'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDE_RETURN: wide <= cfg_data[0];
        CFG_STACK_MASK: smask <= cfg_data[15:0];
        CFG_PROG_MASK: pmask <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      sreg <= '0;
      sp <= 16'hFFFF;
      pc <= '0;
      cnt <= '0;
      o_valid <= 1'b0;
    end else begin
      sreg <= sreg_next;
      sp <= sp_next;
      if (out_ch.ready && !((state == S_DONE) && slot_free)) o_valid <= 1'b0;
      if (fin) begin
        res_pc <= fin_pc;
        res_taken <= fin_taken;
        res_ill <= fin_ill;
        res_cyc <= fin_cyc;
        if (!fin_ill) pc <= fin_pc;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DATA_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (acc) state <= S_EXEC;
        end
        S_EXEC: begin
          cnt <= '0;
          pop_acc <= '0;
          if (fin) state <= S_DONE;
          else if (op_r == OP_ADIW) state <= S_ADIWH;
          else if (op_r == OP_LD) state <= S_LDW;
          else if (op_r == OP_RCALL) state <= S_PUSH;
          else state <= S_POP;
          adiw_hi <= adiw_sum[15:8];
        end
        S_ADIWH, S_LDW: state <= S_DONE;
        S_PUSH, S_POP: begin
          cnt <= cnt + 2'd1;
          pop_acc <= pop_val;
          if (fin) state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            o_valid <= 1'b1;
            o_pc <= res_pc;
            o_sreg <= sreg;
            o_taken <= res_taken;
            o_ill <= res_ill;
            o_cyc <= res_cyc;
            state <= acc ? S_EXEC : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      w_r <= in_ch.instr_word;
      ext_r <= in_ch.extra_word;
      op_r <= decode(in_ch.instr_word);
    end
  end

  assign out_ch.valid = o_valid;
  assign out_ch.next_pc = o_pc;
  assign out_ch.status_flags = o_sreg;
  assign out_ch.taken = o_taken;
  assign out_ch.illegal = o_ill;
  assign out_ch.cycle_count = o_cyc;

`ifndef SYNTHESIS
  a_one_write: assert property (@(posedge clk) disable iff (rst) !(rf_we && dm_we))
    else $error("register file and data memory written together");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst) acc |=> state == S_EXEC)
    else $error("accepted word did not enter execute");
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && state != $past(state) && $past(state) != S_CLEAR) |-> 1'b0)
    else $error("clear sweep re-entered");
  a_no_ready_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ch.ready)
    else $error("input ready during clear sweep");
`endif

endmodule
`default_nettype wire
